FILE: design/gmps_pkg.sv
// Package: shared types, constants and helpers of the grid maze path search block.
`default_nettype none
package gmps_pkg;

  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned CELL_TOTAL = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W     = ROW_W + COL_W;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DIR_W      = 3;
  localparam int unsigned LANES      = 5;
  localparam int unsigned FAIL_W     = LANES * LEN_W;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_ENTRY = 3'd4;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [LEN_W-1:0] FAIL_NONE = '1;

  typedef struct packed {
    logic [1:0]        func;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [1:0]        cell_kind;
    logic [ADDR_W-1:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [LEN_W-1:0]  path_length;
    logic [ROW_W-1:0]  step_row;
    logic [COL_W-1:0]  step_col;
    logic [DIR_W-1:0]  step_dir;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIR_W-1:0] dir;
    logic [DIR_W-1:0] next_try;
  } step_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] max);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > max) r = max;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] fail_lane(input logic [FAIL_W-1:0] row,
                                                 input logic [DIR_W-1:0] sel);
    logic [LEN_W-1:0] r;
    r = FAIL_NONE;
    for (int i = 0; i < LANES; i++) begin
      if (sel == DIR_W'(i)) r = row[i*LEN_W +: LEN_W];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/gmps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module gmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/gmps_engine.sv
// Search engine: maze, fail-depth and path memories plus the walk sequencer.
`default_nettype none
module gmps_engine
  import gmps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output out_item_t      res_item_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_READ     = 10'b0000000010,
    S_SCAN     = 10'b0000000100,
    S_SCAN_END = 10'b0000001000,
    S_START    = 10'b0000010000,
    S_TRY      = 10'b0000100000,
    S_CHECK    = 10'b0001000000,
    S_POP      = 10'b0010000000,
    S_POP2     = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  n_q, n_d, m_q, m_d;
  logic [LEN_W-1:0]  limit_q, limit_d;
  logic [ROW_W-1:0]  scan_r_q, scan_r_d;
  logic [COL_W-1:0]  scan_c_q, scan_c_d;
  logic              chk_v_q;
  logic [ROW_W-1:0]  chk_r_q;
  logic [COL_W-1:0]  chk_c_q;
  logic [ROW_W-1:0]  entry_r_q;
  logic [COL_W-1:0]  entry_c_q;
  logic              entry_v_q, entry_v_d;
  logic              found_q, found_d;
  logic [LEN_W-1:0]  flen_q, flen_d;
  logic [ADDR_W-1:0] d_q, d_d;
  logic [ROW_W-1:0]  cr_q, cr_d, nr_q, nr_d;
  logic [COL_W-1:0]  cc_q, cc_d, nc_q, nc_d;
  logic [DIR_W-1:0]  cd_q, cd_d, k_q, k_d, nk_q, nk_d;
  logic              rd_ok_q, rd_ok_d;
  logic [ROW_W-1:0]  sr_q, sr_d;
  logic [COL_W-1:0]  sc_q, sc_d;
  logic [DIR_W-1:0]  sd_q, sd_d;

  // memory ports
  logic              maze_we;
  logic [ADDR_W-1:0] maze_waddr, maze_raddr;
  logic [1:0]        maze_wdata, maze_rdata;
  logic              fail_we;
  logic [ADDR_W-1:0] fail_waddr, fail_raddr;
  logic [FAIL_W-1:0] fail_wdata, fail_rdata;
  logic              path_we;
  logic [ADDR_W-1:0] path_waddr, path_raddr;
  step_t             path_wdata, path_rdata;

  gmps_ram #(.WIDTH(2), .DEPTH(CELL_TOTAL)) u_maze (
    .clk_i, .we_i(maze_we), .waddr_i(maze_waddr), .wdata_i(maze_wdata),
    .raddr_i(maze_raddr), .rdata_o(maze_rdata)
  );

  gmps_ram #(.WIDTH(FAIL_W), .DEPTH(CELL_TOTAL)) u_fail (
    .clk_i, .we_i(fail_we), .waddr_i(fail_waddr), .wdata_i(fail_wdata),
    .raddr_i(fail_raddr), .rdata_o(fail_rdata)
  );

  gmps_ram #(.WIDTH($bits(step_t)), .DEPTH(CELL_TOTAL)) u_path (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

  // neighbor of the top frame in direction k
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic             blocked, back;
  logic [LEN_W-1:0] d_ext, d_p1, lane;
  logic             in_fire;

  assign d_ext   = {1'b0, d_q};
  assign d_p1    = d_ext + LEN_W'(1);
  assign lane    = fail_lane(fail_rdata, nk_q);
  assign in_fire = in_valid_i && in_ready_o;
  assign back    = (cd_q != DIR_ENTRY) && (k_q[1:0] == cd_q[1:0] + 2'd2);

  always_comb begin
    nb_row  = cr_q;
    nb_col  = cc_q;
    blocked = 1'b0;
    case (k_q)
      DIR_LEFT: begin
        if (cc_q == '0) blocked = 1'b1;
        else nb_col = cc_q - COL_W'(1);
      end
      DIR_UP: begin
        if (cr_q == '0) blocked = 1'b1;
        else nb_row = cr_q - ROW_W'(1);
      end
      DIR_RIGHT: begin
        if ({1'b0, cc_q} + CNT_W'(1) >= m_q) blocked = 1'b1;
        else nb_col = cc_q + COL_W'(1);
      end
      DIR_DOWN: begin
        if ({1'b0, cr_q} + CNT_W'(1) >= n_q) blocked = 1'b1;
        else nb_row = cr_q + ROW_W'(1);
      end
      default: blocked = 1'b1;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    m_d       = m_q;
    limit_d   = limit_q;
    scan_r_d  = scan_r_q;
    scan_c_d  = scan_c_q;
    entry_v_d = entry_v_q;
    found_d   = found_q;
    flen_d    = flen_q;
    d_d       = d_q;
    cr_d      = cr_q;
    cc_d      = cc_q;
    cd_d      = cd_q;
    k_d       = k_q;
    nr_d      = nr_q;
    nc_d      = nc_q;
    nk_d      = nk_q;
    rd_ok_d   = rd_ok_q;
    sr_d      = sr_q;
    sc_d      = sc_q;
    sd_d      = sd_q;

    maze_we    = 1'b0;
    maze_waddr = {in_item_i.cell_row, in_item_i.cell_col};
    maze_wdata = in_item_i.cell_kind;
    maze_raddr = {nb_row, nb_col};
    fail_we    = 1'b0;
    fail_waddr = {cr_q, cc_q};
    fail_wdata = fail_rdata;
    fail_raddr = {nb_row, nb_col};
    path_we    = 1'b0;
    path_waddr = d_q;
    path_wdata = '{row: cr_q, col: cc_q, dir: cd_q, next_try: k_q + DIR_W'(1)};
    path_raddr = in_item_i.step_index;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_item_i.func)
            FUNC_WRITE: maze_we = 1'b1;
            FUNC_SEARCH: begin
              n_d       = clamp_count(cfg_i.rows, CNT_W'(MAX_ROWS));
              m_d       = clamp_count(cfg_i.cols, CNT_W'(MAX_COLS));
              limit_d   = LEN_W'(n_d) * LEN_W'(m_d);
              scan_r_d  = '0;
              scan_c_d  = '0;
              entry_v_d = 1'b0;
              found_d   = 1'b0;
              flen_d    = '0;
              sr_d      = '0;
              sc_d      = '0;
              sd_d      = '0;
              state_d   = S_SCAN;
            end
            FUNC_READ: begin
              rd_ok_d = found_q && ({1'b0, in_item_i.step_index} < flen_q);
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        sr_d    = rd_ok_q ? path_rdata.row : '0;
        sc_d    = rd_ok_q ? path_rdata.col : '0;
        sd_d    = rd_ok_q ? path_rdata.dir : '0;
        state_d = S_DONE;
      end
      S_SCAN: begin
        maze_raddr = {scan_r_q, scan_c_q};
        fail_we    = 1'b1;
        fail_waddr = {scan_r_q, scan_c_q};
        fail_wdata = '1;
        if ({1'b0, scan_c_q} + CNT_W'(1) == m_q) begin
          scan_c_d = '0;
          if ({1'b0, scan_r_q} + CNT_W'(1) == n_q) state_d = S_SCAN_END;
          else scan_r_d = scan_r_q + ROW_W'(1);
        end else begin
          scan_c_d = scan_c_q + COL_W'(1);
        end
      end
      S_SCAN_END: state_d = S_START;
      S_START: begin
        if (!entry_v_q) begin
          state_d = S_DONE;
        end else begin
          path_we    = 1'b1;
          path_waddr = '0;
          path_wdata = '{row: entry_r_q, col: entry_c_q, dir: DIR_ENTRY, next_try: '0};
          d_d        = '0;
          cr_d       = entry_r_q;
          cc_d       = entry_c_q;
          cd_d       = DIR_ENTRY;
          k_d        = '0;
          state_d    = S_TRY;
        end
      end
      S_TRY: begin
        if (k_q[2]) begin
          state_d = S_POP;
        end else begin
          k_d = k_q + DIR_W'(1);
          if (!back && !blocked) begin
            nr_d    = nb_row;
            nc_d    = nb_col;
            nk_d    = k_q;
            path_we = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_d = S_TRY;
        if (maze_rdata != KIND_WALL && d_p1 < limit_q && lane > d_p1) begin
          path_we    = 1'b1;
          path_waddr = d_p1[ADDR_W-1:0];
          path_wdata = '{row: nr_q, col: nc_q, dir: nk_q, next_try: '0};
          if (maze_rdata == KIND_EXIT) begin
            found_d = 1'b1;
            flen_d  = d_ext + LEN_W'(2);
            state_d = S_DONE;
          end else begin
            d_d  = d_p1[ADDR_W-1:0];
            cr_d = nr_q;
            cc_d = nc_q;
            cd_d = nk_q;
            k_d  = '0;
          end
        end
      end
      S_POP: begin
        fail_raddr = {cr_q, cc_q};
        path_raddr = d_q - ADDR_W'(1);
        state_d    = S_POP2;
      end
      S_POP2: begin
        fail_we = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          if (cd_q == DIR_W'(i) && fail_rdata[i*LEN_W +: LEN_W] > d_ext) begin
            fail_wdata[i*LEN_W +: LEN_W] = d_ext;
          end
        end
        if (d_q == '0) begin
          state_d = S_DONE;
        end else begin
          d_d     = d_q - ADDR_W'(1);
          cr_d    = path_rdata.row;
          cc_d    = path_rdata.col;
          cd_d    = path_rdata.dir;
          k_d     = path_rdata.next_try;
          state_d = S_TRY;
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_item_o  = '{status: !entry_v_q, found: found_q, path_length: flen_q,
                         step_row: sr_q, step_col: sc_q, step_dir: sd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      entry_v_q <= 1'b0;
      entry_r_q <= '0;
      entry_c_q <= '0;
      found_q   <= 1'b0;
      flen_q    <= '0;
      chk_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      found_q   <= found_d;
      flen_q    <= flen_d;
      chk_v_q   <= (state_q == S_SCAN);
      if (chk_v_q && maze_rdata == KIND_ENTRY) begin
        entry_v_q <= 1'b1;
        entry_r_q <= chk_r_q;
        entry_c_q <= chk_c_q;
      end else begin
        entry_v_q <= entry_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    m_q      <= m_d;
    limit_q  <= limit_d;
    scan_r_q <= scan_r_d;
    scan_c_q <= scan_c_d;
    chk_r_q  <= scan_r_q;
    chk_c_q  <= scan_c_q;
    d_q      <= d_d;
    cr_q     <= cr_d;
    cc_q     <= cc_d;
    cd_q     <= cd_d;
    k_q      <= k_d;
    nr_q     <= nr_d;
    nc_q     <= nc_d;
    nk_q     <= nk_d;
    rd_ok_q  <= rd_ok_d;
    sr_q     <= sr_d;
    sc_q     <= sc_d;
    sd_q     <= sd_d;
  end

endmodule
`default_nettype wire

FILE: design/grid_maze_path_search_top.sv
// Top level: configuration registers, engine and output item register.
// Cell load: written from the idle state. Path step read: memory read, S_READ, S_DONE, output register.
// Search: entry scan over rows*cols cells, then a depth-first walk in which each direction
// is skipped, tried (S_TRY, S_CHECK) or backtracked (S_POP, S_POP2) through the memory reads.
// One item at a time; the next item can be taken while one result waits in the output register.
// Reset: rows and columns 64, no entry, no path; memories hold no reset.
`default_nettype none
module grid_maze_path_search_top
  import gmps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CNT_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      res_valid, res_ready;
  out_item_t res_item;
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rows: CNT_W'(MAX_ROWS), cols: CNT_W'(MAX_COLS)};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS: cfg_q.rows <= cfg_data_i;
        REG_COLS: cfg_q.cols <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gmps_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_ready_o, .in_item_i,
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_item_o(res_item)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_item_q <= res_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_found_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> !out_item_o.status)
    else $error("found without entry");
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.path_length == '0)
    else $error("length without path");
  a_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.step_dir == '0)
    else $error("step without path");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.func == FUNC_SEARCH |=> !in_ready_o)
    else $error("search not held busy");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_grid_maze_path_search_top.sv
// Testbench: grid maze path search top, checked item by item against a built-in search predictor.
`timescale 1ns / 1ps
module tb_grid_maze_path_search_top;
  import gmps_pkg::*;

  localparam logic [1:0] FUNC_IDLE = 2'd3;
  localparam int unsigned NO_FAIL = 32'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 30_000_000;

  class maze_path_predictor;
    logic [1:0]       cells [CELL_TOTAL];
    logic [CNT_W-1:0] rows_reg;
    logic [CNT_W-1:0] cols_reg;
    int unsigned      entry_r;
    int unsigned      entry_c;
    bit               entry_ok;
    bit               path_found;
    int unsigned      path_len;
    int unsigned      stk_row [CELL_TOTAL];
    int unsigned      stk_col [CELL_TOTAL];
    int unsigned      stk_dir [CELL_TOTAL];
    int unsigned      next_dir [CELL_TOTAL];
    int unsigned      fail_depth [CELL_TOTAL][5];
    out_item_t        expected_results [$];
    int               mismatch_count;

    function void reset_state();
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      foreach (cells[i]) cells[i] = KIND_OPEN;
      entry_r = 0;
      entry_c = 0;
      entry_ok = 0;
      path_found = 0;
      path_len = 0;
      mismatch_count = 0;
    endfunction

    function int unsigned clamp_dim(logic [CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function int try_enter(int unsigned r, int unsigned c, int unsigned dir,
                           int unsigned d, int unsigned limit);
      int unsigned idx;
      idx = r * MAX_COLS + c;
      if (d >= limit || fail_depth[idx][dir] <= d) return 0;
      stk_row[d] = r;
      stk_col[d] = c;
      stk_dir[d] = dir;
      if (cells[idx] == KIND_EXIT) return 2;
      next_dir[d] = 0;
      return 1;
    endfunction

    function void run_search();
      int unsigned n, m, limit, d, cr, cc, cd, k, nr, nc, idx;
      int res;
      bit blocked;
      n = clamp_dim(rows_reg);
      m = clamp_dim(cols_reg);
      limit = n * m;
      entry_ok = 0;
      path_found = 0;
      path_len = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < m; c++)
          if (cells[r * MAX_COLS + c] == KIND_ENTRY) begin
            entry_r = r;
            entry_c = c;
            entry_ok = 1;
          end
      if (!entry_ok) return;
      foreach (fail_depth[i, j]) fail_depth[i][j] = NO_FAIL;
      if (try_enter(entry_r, entry_c, DIR_ENTRY, 0, limit) != 1) return;
      d = 0;
      while (1) begin
        cr = stk_row[d];
        cc = stk_col[d];
        cd = stk_dir[d];
        if (next_dir[d] >= 4) begin
          idx = cr * MAX_COLS + cc;
          if (fail_depth[idx][cd] > d) fail_depth[idx][cd] = d;
          if (d == 0) return;
          d--;
          continue;
        end
        k = next_dir[d];
        next_dir[d]++;
        if (cd != DIR_ENTRY && k == ((cd + 2) & 3)) continue;
        nr = cr;
        nc = cc;
        blocked = 0;
        case (k)
          DIR_LEFT:  if (cc == 0) blocked = 1; else nc = cc - 1;
          DIR_UP:    if (cr == 0) blocked = 1; else nr = cr - 1;
          DIR_RIGHT: if (cc + 1 >= m) blocked = 1; else nc = cc + 1;
          default:   if (cr + 1 >= n) blocked = 1; else nr = cr + 1;
        endcase
        if (blocked) continue;
        if (cells[nr * MAX_COLS + nc] == KIND_WALL) continue;
        res = try_enter(nr, nc, k, d + 1, limit);
        if (res == 2) begin
          path_found = 1;
          path_len = d + 2;
          return;
        end
        if (res == 1) d++;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.func)
        FUNC_WRITE: cells[it.cell_row * MAX_COLS + it.cell_col] = it.cell_kind;
        FUNC_SEARCH, FUNC_READ: begin
          if (it.func == FUNC_SEARCH) run_search();
          else if (path_found && it.step_index < path_len) begin
            r.step_row = ROW_W'(stk_row[it.step_index]);
            r.step_col = COL_W'(stk_col[it.step_index]);
            r.step_dir = DIR_W'(stk_dir[it.step_index]);
          end
          r.status = !entry_ok;
          r.found = path_found;
          r.path_length = LEN_W'(path_len);
          expected_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        mismatch_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result item %h", got);
        mismatch_count++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("status", e.status, got.status);
      compare_field("found", e.found, got.found);
      compare_field("path_length", e.path_length, got.path_length);
      compare_field("step_row", e.step_row, got.step_row);
      compare_field("step_col", e.step_col, got.step_col);
      compare_field("step_dir", e.step_dir, got.step_dir);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_item_o;
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [CNT_W-1:0] cfg_data_i;

  maze_path_predictor maze_model;
  int unsigned cycle_count;
  int unsigned hold_request;
  bit          ready_always;
  bit          sender_fast;
  int unsigned cur_rows;
  int unsigned cur_cols;

  grid_maze_path_search_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) maze_model.check_result(out_item_o);
  end

  initial begin : receiver
    int unsigned stall_left;
    int unsigned pick;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (ready_always) begin
        out_ready_i <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          stall_left = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (sender_fast) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    maze_model.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [1:0] func, int unsigned r, int unsigned c,
                         int unsigned kind, int unsigned idx);
    in_item_t it;
    it.func = func;
    it.cell_row = ROW_W'(r);
    it.cell_col = COL_W'(c);
    it.cell_kind = 2'(kind);
    it.step_index = ADDR_W'(idx);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (maze_model.expected_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_config(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_ROWS;
    cfg_data_i <= rows;
    @(negedge clk_i);
    cfg_index_i <= REG_COLS;
    cfg_data_i <= cols;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    maze_model.rows_reg = rows;
    maze_model.cols_reg = cols;
    cur_rows = maze_model.clamp_dim(rows);
    cur_cols = maze_model.clamp_dim(cols);
  endtask

  function automatic logic [1:0] random_kind(int unsigned wall_pct, bit with_entry);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < wall_pct) return KIND_WALL;
    if (pick < wall_pct + 8) return KIND_EXIT;
    if (with_entry && pick < wall_pct + 12) return KIND_ENTRY;
    return KIND_OPEN;
  endfunction

  task automatic run_phase(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols,
                           int unsigned wall_pct, int unsigned item_total,
                           int unsigned hold = 0);
    int unsigned pick;
    write_config(rows, cols);
    for (int r = 0; r < cur_rows; r++)
      for (int c = 0; c < cur_cols; c++)
        send_op(FUNC_WRITE, r, c, random_kind(wall_pct, 0), $urandom_range(0, 4095));
    send_op(FUNC_SEARCH, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_WRITE, $urandom_range(0, cur_rows - 1), $urandom_range(0, cur_cols - 1),
            KIND_ENTRY, 0);
    hold_request = hold;
    for (int i = 0; i < item_total; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_op(FUNC_WRITE, $urandom_range(0, cur_rows - 1), $urandom_range(0, cur_cols - 1),
                random_kind(wall_pct, 1), $urandom_range(0, 4095));
      else if (pick < 62)
        send_op(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 3), 0);
      else if (pick < 75)
        send_op(FUNC_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 3), $urandom_range(0, 4095));
      else if (pick < 97)
        send_op(FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, maze_model.path_len + 1));
      else
        send_op(FUNC_IDLE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 3), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    maze_model = new();
    maze_model.reset_state();
    cycle_count = 0;
    hold_request = 0;
    ready_always = 0;
    sender_fast = 0;
    cur_rows = 64;
    cur_cols = 64;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_ROWS;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // before any search: status says no entry
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_READ, 63, 63, KIND_EXIT, 4095);
    send_op(FUNC_IDLE, 63, 63, KIND_EXIT, 4095);
    // zero registers act as one
    write_config(7'd0, 7'd0);
    send_op(FUNC_WRITE, 0, 0, KIND_ENTRY, 0);
    send_op(FUNC_SEARCH, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_WRITE, 0, 0, KIND_EXIT, 0);
    send_op(FUNC_SEARCH, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_WRITE, 63, 63, KIND_WALL, 4095);
    write_config(7'd1, 7'd2);
    send_op(FUNC_WRITE, 0, 0, KIND_ENTRY, 0);
    send_op(FUNC_WRITE, 0, 1, KIND_EXIT, 0);
    send_op(FUNC_SEARCH, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 1);
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 2);
    write_config(7'd2, 7'd1);
    send_op(FUNC_WRITE, 0, 0, KIND_EXIT, 0);
    send_op(FUNC_WRITE, 1, 0, KIND_ENTRY, 0);
    send_op(FUNC_SEARCH, 0, 0, KIND_OPEN, 0);
    send_op(FUNC_READ, 0, 0, KIND_OPEN, 1);

    run_phase(7'd2, 7'd3, 20, 40);
    run_phase(7'd5, 7'd5, 25, 80, 400);
    ready_always = 1;
    sender_fast = 1;
    run_phase(7'd3, 7'd6, 25, 60);
    ready_always = 0;
    sender_fast = 0;
    run_phase(7'd127, 7'd1, 10, 40);
    run_phase(7'd1, 7'd64, 10, 40);
    run_phase(7'd6, 7'd7, 30, 100);
    run_phase(7'd8, 7'd8, 35, 100, 300);
    run_phase(7'd4, 7'd12, 30, 80);
    run_phase(7'd7, 7'd5, 25, 100);

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (maze_model.mismatch_count == 0 && maze_model.expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
